FILE: hw/rtl/dpec_pkg.sv
// Package for the disk pair elastic collision block.
// Holds the payload types, the pipeline stage record, stage numbers and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package dpec_pkg;

    localparam int DT_BITS    = 16;
    localparam int DV_BITS    = 34;
    localparam int SQRT_BITS  = 25;
    localparam int NG_BITS    = 26;

    localparam int ST_CTR      = 1;
    localparam int ST_DIFF     = 2;
    localparam int ST_MUL      = 3;
    localparam int ST_SUM      = 4;
    localparam int ST_ABS      = 5;
    localparam int ST_PP       = 6;
    localparam int ST_NUM      = 7;
    localparam int ST_DV_FIRST = 8;
    localparam int ST_DV_LAST  = ST_DV_FIRST + DV_BITS - 1;
    localparam int ST_SQ_FIRST = 5;
    localparam int ST_SQ_LAST  = ST_SQ_FIRST + SQRT_BITS - 1;
    localparam int ST_NUDGE_A  = ST_SQ_LAST + 1;
    localparam int ST_NUDGE_M  = ST_NUDGE_A + 1;
    localparam int ST_NG_FIRST = ST_NUDGE_M + 1;
    localparam int ST_NG_LAST  = ST_NG_FIRST + NG_BITS - 1;
    localparam int ST_OUT      = ST_NG_LAST + 1;
    localparam int N_STAGES    = ST_OUT + 1;

    localparam logic ADDR_TIME_STEP   = 1'b0;
    localparam logic ADDR_SIDE_BORDER = 1'b1;
    localparam logic [15:0] TIME_STEP_RESET = 16'd1024;

    typedef struct packed {
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic        [23:0] first_radius;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
        logic        [23:0] second_radius;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_first_pos_x;
        logic signed [31:0] new_first_pos_y;
        logic signed [31:0] new_first_vel_x;
        logic signed [31:0] new_first_vel_y;
        logic signed [31:0] new_second_pos_x;
        logic signed [31:0] new_second_pos_y;
        logic signed [31:0] new_second_vel_x;
        logic signed [31:0] new_second_vel_y;
        logic               collided;
    } t_out;

    typedef struct packed {
        t_in                pay;
        logic signed [48:0] pv1x;
        logic signed [48:0] pv1y;
        logic signed [48:0] pv2x;
        logic signed [48:0] pv2y;
        logic signed [33:0] c1x;
        logic signed [33:0] c1y;
        logic signed [33:0] c2x;
        logic signed [33:0] c2y;
        logic               side;
        logic signed [34:0] dx;
        logic signed [34:0] dy;
        logic        [24:0] rs;
        logic signed [32:0] vrx;
        logic signed [32:0] vry;
        logic               inr;
        logic        [50:0] sqx;
        logic        [50:0] sqy;
        logic        [49:0] rsq;
        logic signed [58:0] pdx;
        logic signed [58:0] pdy;
        logic        [50:0] nsq;
        logic signed [59:0] dot;
        logic               hit;
        logic        [24:0] adx;
        logic        [24:0] ady;
        logic        [57:0] adot;
        logic               sgx;
        logic               sgy;
        logic        [53:0] ppxl;
        logic        [53:0] ppxh;
        logic        [53:0] ppyl;
        logic        [53:0] ppyh;
        logic        [82:0] numx;
        logic        [82:0] numy;
        logic        [49:0] remx;
        logic        [49:0] remy;
        logic        [DV_BITS-1:0] qx;
        logic        [DV_BITS-1:0] qy;
        logic        [26:0] srem;
        logic        [SQRT_BITS-1:0] root;
        logic        [25:0] aa1;
        logic        [25:0] aa2;
        logic        [3:0]  ns;
        logic        [25:0] dm;
        logic [3:0][50:0]   nn;
        logic [3:0][25:0]   nr;
        logic [3:0][NG_BITS-1:0] nq;
        t_out               res;
    } t_st;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        logic signed [31:0] y;
        if (x[35:31] == 5'b00000 || x[35:31] == 5'b11111) begin
            y = x[31:0];
        end else if (x[35]) begin
            y = 32'sh80000000;
        end else begin
            y = 32'sh7FFFFFFF;
        end
        return y;
    endfunction

endpackage

FILE: hw/rtl/disk_pair_elastic_collision.sv
// Top level of the disk pair elastic collision block: APB registers and the compute pipeline.
// Depends on dpec_pkg for payload types, stage numbers and saturation.
//
// Accepts one disk pair per clock while i_out_ready does not stall the output. The pipeline
// depth is set by the square root (one result bit per stage) followed by the nudge division
// (one quotient bit per stage); the velocity division runs alongside. Each stage holds its item
// until the next stage frees, so empty stages close up while the output waits for a transfer.
`timescale 1ns / 1ps

module disk_pair_elastic_collision (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dpec_pkg::t_in       i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dpec_pkg::t_out      o_out
);
    import dpec_pkg::*;

    logic [15:0]        r_time_step;
    logic signed [31:0] r_side_border;
    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES-1:0] en;
    t_st r_st [N_STAGES];
    t_st n_st [N_STAGES];

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == ADDR_SIDE_BORDER) ? r_side_border : {16'b0, r_time_step};
    assign o_in_ready  = en[0];
    assign o_out_valid = r_v[N_STAGES-1];
    assign o_out       = r_st[N_STAGES-1].res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step   <= TIME_STEP_RESET;
            r_side_border <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                ADDR_TIME_STEP:   r_time_step   <= pwdata[15:0];
                ADDR_SIDE_BORDER: r_side_border <= pwdata;
                default:          r_time_step   <= r_time_step;
            endcase
        end
    end

    always_comb begin
        en[N_STAGES-1] = !r_v[N_STAGES-1] || i_out_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_STAGES; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin
        logic signed [48:0] t_n1x, t_n1y, t_n2x, t_n2y;
        logic signed [34:0] t_rs;
        logic signed [25:0] t_dx26, t_dy26;
        logic        [50:0] t_dv;
        logic        [28:0] t_sq, t_tr;
        logic        [26:0] t_srem;
        logic        [SQRT_BITS-1:0] t_root;
        logic signed [26:0] t_a1, t_a2;
        logic        [26:0] t_ng;
        logic signed [35:0] t_p, t_q;
        int j;

        n_st[0]      = '0;
        n_st[0].pay  = i_in;
        n_st[0].pv1x = i_in.first_vel_x * $signed({1'b0, r_time_step});
        n_st[0].pv1y = i_in.first_vel_y * $signed({1'b0, r_time_step});
        n_st[0].pv2x = i_in.second_vel_x * $signed({1'b0, r_time_step});
        n_st[0].pv2y = i_in.second_vel_y * $signed({1'b0, r_time_step});

        for (int k = 1; k < N_STAGES; k++) begin
            t_n1x = '0; t_n1y = '0; t_n2x = '0; t_n2y = '0;
            t_rs = '0; t_dx26 = '0; t_dy26 = '0; t_dv = '0;
            t_sq = '0; t_tr = '0; t_srem = '0; t_root = '0;
            t_a1 = '0; t_a2 = '0; t_ng = '0; t_p = '0; t_q = '0;
            j = 0;
            n_st[k] = r_st[k-1];

            if (k == ST_CTR) begin
                t_n1x = r_st[k-1].pay.first_pos_x + (r_st[k-1].pv1x >>> DT_BITS);
                t_n1y = r_st[k-1].pay.first_pos_y + (r_st[k-1].pv1y >>> DT_BITS);
                t_n2x = r_st[k-1].pay.second_pos_x + (r_st[k-1].pv2x >>> DT_BITS);
                t_n2y = r_st[k-1].pay.second_pos_y + (r_st[k-1].pv2y >>> DT_BITS);
                n_st[k].c1x = 34'(t_n1x + $signed({1'b0, r_st[k-1].pay.first_radius}));
                n_st[k].c1y = 34'(t_n1y + $signed({1'b0, r_st[k-1].pay.first_radius}));
                n_st[k].c2x = 34'(t_n2x + $signed({1'b0, r_st[k-1].pay.second_radius}));
                n_st[k].c2y = 34'(t_n2y + $signed({1'b0, r_st[k-1].pay.second_radius}));
                n_st[k].side = (t_n1x < r_side_border) == (t_n2x < r_side_border);
            end

            if (k == ST_DIFF) begin
                n_st[k].dx  = r_st[k-1].c2x - r_st[k-1].c1x;
                n_st[k].dy  = r_st[k-1].c2y - r_st[k-1].c1y;
                n_st[k].rs  = r_st[k-1].pay.first_radius + r_st[k-1].pay.second_radius;
                n_st[k].vrx = r_st[k-1].pay.first_vel_x - r_st[k-1].pay.second_vel_x;
                n_st[k].vry = r_st[k-1].pay.first_vel_y - r_st[k-1].pay.second_vel_y;
            end

            if (k == ST_MUL) begin
                t_rs   = $signed({10'b0, r_st[k-1].rs});
                t_dx26 = r_st[k-1].dx[25:0];
                t_dy26 = r_st[k-1].dy[25:0];
                n_st[k].inr = (r_st[k-1].dx <= t_rs) && (r_st[k-1].dx >= -t_rs)
                           && (r_st[k-1].dy <= t_rs) && (r_st[k-1].dy >= -t_rs);
                n_st[k].sqx = t_dx26 * t_dx26;
                n_st[k].sqy = t_dy26 * t_dy26;
                n_st[k].rsq = r_st[k-1].rs * r_st[k-1].rs;
                n_st[k].pdx = r_st[k-1].vrx * t_dx26;
                n_st[k].pdy = r_st[k-1].vry * t_dy26;
            end

            if (k == ST_SUM) begin
                n_st[k].nsq = r_st[k-1].sqx + r_st[k-1].sqy;
                n_st[k].dot = r_st[k-1].pdx + r_st[k-1].pdy;
                n_st[k].hit = r_st[k-1].side && r_st[k-1].inr
                           && (n_st[k].nsq != '0) && (n_st[k].nsq <= {1'b0, r_st[k-1].rsq});
            end

            if (k == ST_ABS) begin
                n_st[k].adx  = r_st[k-1].dx[34] ? 25'(-r_st[k-1].dx) : 25'(r_st[k-1].dx);
                n_st[k].ady  = r_st[k-1].dy[34] ? 25'(-r_st[k-1].dy) : 25'(r_st[k-1].dy);
                n_st[k].adot = r_st[k-1].dot[59] ? 58'(-r_st[k-1].dot) : 58'(r_st[k-1].dot);
                n_st[k].sgx  = r_st[k-1].dx[34] ^ r_st[k-1].dot[59];
                n_st[k].sgy  = r_st[k-1].dy[34] ^ r_st[k-1].dot[59];
            end

            if (k == ST_PP) begin
                n_st[k].ppxl = r_st[k-1].adx * r_st[k-1].adot[28:0];
                n_st[k].ppxh = r_st[k-1].adx * r_st[k-1].adot[57:29];
                n_st[k].ppyl = r_st[k-1].ady * r_st[k-1].adot[28:0];
                n_st[k].ppyh = r_st[k-1].ady * r_st[k-1].adot[57:29];
            end

            if (k == ST_NUM) begin
                n_st[k].numx = 83'(r_st[k-1].ppxl) + {r_st[k-1].ppxh, 29'b0};
                n_st[k].numy = 83'(r_st[k-1].ppyl) + {r_st[k-1].ppyh, 29'b0};
                n_st[k].remx = {1'b0, n_st[k].numx[82:DV_BITS]};
                n_st[k].remy = {1'b0, n_st[k].numy[82:DV_BITS]};
            end

            if (k >= ST_DV_FIRST && k <= ST_DV_LAST) begin
                j = ST_DV_LAST - k;
                t_dv = {r_st[k-1].remx, r_st[k-1].numx[j]};
                if (t_dv >= {1'b0, r_st[k-1].nsq[49:0]}) begin
                    t_dv = t_dv - {1'b0, r_st[k-1].nsq[49:0]};
                    n_st[k].qx[j] = 1'b1;
                end else begin
                    n_st[k].qx[j] = 1'b0;
                end
                n_st[k].remx = t_dv[49:0];
                t_dv = {r_st[k-1].remy, r_st[k-1].numy[j]};
                if (t_dv >= {1'b0, r_st[k-1].nsq[49:0]}) begin
                    t_dv = t_dv - {1'b0, r_st[k-1].nsq[49:0]};
                    n_st[k].qy[j] = 1'b1;
                end else begin
                    n_st[k].qy[j] = 1'b0;
                end
                n_st[k].remy = t_dv[49:0];
            end

            if (k >= ST_SQ_FIRST && k <= ST_SQ_LAST) begin
                j = ST_SQ_LAST - k;
                t_srem = (k == ST_SQ_FIRST) ? '0 : r_st[k-1].srem;
                t_root = (k == ST_SQ_FIRST) ? '0 : r_st[k-1].root;
                t_sq = {t_srem, r_st[k-1].nsq[2*j +: 2]};
                t_tr = {2'b0, t_root, 2'b01};
                if (t_sq >= t_tr) begin
                    n_st[k].srem = 27'(t_sq - t_tr);
                    n_st[k].root = {t_root[SQRT_BITS-2:0], 1'b1};
                end else begin
                    n_st[k].srem = t_sq[26:0];
                    n_st[k].root = {t_root[SQRT_BITS-2:0], 1'b0};
                end
            end

            if (k == ST_NUDGE_A) begin
                t_a1 = $signed({2'b0, r_st[k-1].pay.first_radius, 1'b0})
                     - $signed({2'b0, r_st[k-1].root});
                t_a2 = $signed({2'b0, r_st[k-1].pay.second_radius, 1'b0})
                     - $signed({2'b0, r_st[k-1].root});
                n_st[k].aa1 = t_a1[26] ? 26'(-t_a1) : 26'(t_a1);
                n_st[k].aa2 = t_a2[26] ? 26'(-t_a2) : 26'(t_a2);
                n_st[k].ns[0] = r_st[k-1].dx[34] ^ t_a1[26];
                n_st[k].ns[1] = r_st[k-1].dy[34] ^ t_a1[26];
                n_st[k].ns[2] = r_st[k-1].dx[34] ^ t_a2[26];
                n_st[k].ns[3] = r_st[k-1].dy[34] ^ t_a2[26];
                n_st[k].dm = {r_st[k-1].root, 1'b0};
            end

            if (k == ST_NUDGE_M) begin
                n_st[k].nn[0] = r_st[k-1].adx * r_st[k-1].aa1;
                n_st[k].nn[1] = r_st[k-1].ady * r_st[k-1].aa1;
                n_st[k].nn[2] = r_st[k-1].adx * r_st[k-1].aa2;
                n_st[k].nn[3] = r_st[k-1].ady * r_st[k-1].aa2;
                for (int i = 0; i < 4; i++) begin
                    n_st[k].nr[i] = {1'b0, n_st[k].nn[i][50:NG_BITS]};
                end
            end

            if (k >= ST_NG_FIRST && k <= ST_NG_LAST) begin
                j = ST_NG_LAST - k;
                for (int i = 0; i < 4; i++) begin
                    t_ng = {r_st[k-1].nr[i], r_st[k-1].nn[i][j]};
                    if (t_ng >= {1'b0, r_st[k-1].dm}) begin
                        t_ng = t_ng - {1'b0, r_st[k-1].dm};
                        n_st[k].nq[i][j] = 1'b1;
                    end else begin
                        n_st[k].nq[i][j] = 1'b0;
                    end
                    n_st[k].nr[i] = t_ng[25:0];
                end
            end

            if (k == ST_OUT) begin
                n_st[k].res.new_first_pos_x  = r_st[k-1].pay.first_pos_x;
                n_st[k].res.new_first_pos_y  = r_st[k-1].pay.first_pos_y;
                n_st[k].res.new_first_vel_x  = r_st[k-1].pay.first_vel_x;
                n_st[k].res.new_first_vel_y  = r_st[k-1].pay.first_vel_y;
                n_st[k].res.new_second_pos_x = r_st[k-1].pay.second_pos_x;
                n_st[k].res.new_second_pos_y = r_st[k-1].pay.second_pos_y;
                n_st[k].res.new_second_vel_x = r_st[k-1].pay.second_vel_x;
                n_st[k].res.new_second_vel_y = r_st[k-1].pay.second_vel_y;
                n_st[k].res.collided         = r_st[k-1].hit;
                if (r_st[k-1].hit) begin
                    t_p = r_st[k-1].pay.first_pos_x;
                    t_q = $signed({10'b0, r_st[k-1].nq[0]});
                    n_st[k].res.new_first_pos_x = sat32(r_st[k-1].ns[0] ? t_p - t_q : t_p + t_q);
                    t_p = r_st[k-1].pay.first_pos_y;
                    t_q = $signed({10'b0, r_st[k-1].nq[1]});
                    n_st[k].res.new_first_pos_y = sat32(r_st[k-1].ns[1] ? t_p - t_q : t_p + t_q);
                    t_p = r_st[k-1].pay.second_pos_x;
                    t_q = $signed({10'b0, r_st[k-1].nq[2]});
                    n_st[k].res.new_second_pos_x = sat32(r_st[k-1].ns[2] ? t_p + t_q : t_p - t_q);
                    t_p = r_st[k-1].pay.second_pos_y;
                    t_q = $signed({10'b0, r_st[k-1].nq[3]});
                    n_st[k].res.new_second_pos_y = sat32(r_st[k-1].ns[3] ? t_p + t_q : t_p - t_q);
                    t_q = $signed({2'b0, r_st[k-1].qx});
                    t_p = r_st[k-1].pay.first_vel_x;
                    n_st[k].res.new_first_vel_x = sat32(r_st[k-1].sgx ? t_p + t_q : t_p - t_q);
                    t_p = r_st[k-1].pay.second_vel_x;
                    n_st[k].res.new_second_vel_x = sat32(r_st[k-1].sgx ? t_p - t_q : t_p + t_q);
                    t_q = $signed({2'b0, r_st[k-1].qy});
                    t_p = r_st[k-1].pay.first_vel_y;
                    n_st[k].res.new_first_vel_y = sat32(r_st[k-1].sgy ? t_p + t_q : t_p - t_q);
                    t_p = r_st[k-1].pay.second_vel_y;
                    n_st[k].res.new_second_vel_y = sat32(r_st[k-1].sgy ? t_p - t_q : t_p + t_q);
                end
            end
        end
    end

endmodule
